[src/true_lru_way_replacement_top_assert.svh]
// assertion macros of the lru replacement checker
`ifndef TRUE_LRU_WAY_REPLACEMENT_TOP_ASSERT_SVH
`define TRUE_LRU_WAY_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TLRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TLRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tlru_pkg.sv]
// constants, types and helpers of the true lru replacement block
package tlru_pkg;

    localparam int SETS    = 64;
    localparam int WAYS    = 8;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int ORDER_W = WAYS * WAY_W;

    // fixed field widths of the stream words
    localparam int SET_FIELD_W = 6;
    localparam int WAY_FIELD_W = 3;
    localparam int VICTIM_W    = 3;

    typedef logic [ORDER_W-1:0] order_t;

    typedef enum logic {
        MODE_QUERY = 1'b0,
        MODE_TOUCH = 1'b1
    } mode_t;

    // order after reset: way 0 at the lru end, last way at the mru end
    function automatic order_t reset_order();
        order_t o;
        o = '0;
        for (int i = 0; i < WAYS; i++) begin
            o[i*WAY_W +: WAY_W] = WAY_W'(i);
        end
        return o;
    endfunction

endpackage

[src/true_lru_way_replacement_top.sv]
// true lru replacement state for a set-associative cache, top level
//
// Keeps, for every cache set, the full recency order of its ways in one
// synchronous memory, one entry per set (position 0 = lru, last = mru).
// A query word (s_tuser = 0) returns the lru way of the set as a result
// word on m_*; a touch word (s_tuser = 1) moves the named way to the mru
// end and returns nothing. The accept edge issues the memory read; the next
// cycle reorders the entry and, for a touch, writes it back through the same
// single port. s_tready stays low while an item is in flight, so a new word
// is taken only after the last one is done. A query result sits in an output
// register; if it is still not taken when the next query finishes, that
// query waits in the modify state. The memory needs no clearing pass: a valid
// flop per set marks entries written since reset, and an unwritten entry reads
// as the reset order. Touches of an out-of-range way or set are ignored; a
// query of an out-of-range set returns way 0.
module true_lru_way_replacement_top
    import tlru_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] set_index, [8:6] way, [15:9] zero
    input  logic [0:0]  s_tuser,   // [0] mode: 0 query, 1 touch
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [2:0] victim_way, [7:3] zero
);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t state_reg;

    // input word fields
    logic [SET_FIELD_W-1:0] in_set;
    logic [WAY_FIELD_W-1:0] in_way;
    mode_t                  in_mode;
    logic [SET_W-1:0]       in_addr;
    logic                   in_set_ok;
    logic                   in_way_ok;
    logic                   s_accept;

    // captured item, used in the modify cycle
    mode_t                  item_mode_reg;
    logic [WAY_W-1:0]       item_way_reg;
    logic [SET_W-1:0]       item_addr_reg;
    logic                   item_set_ok_reg;
    logic                   item_way_ok_reg;

    // recency memory and its per-set written flags
    order_t                 order_mem [SETS];
    order_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic [SETS-1:0]        valid_reg;

    // reorder logic
    order_t                 cur_order;
    order_t                 new_order;
    logic [WAYS-1:0]        match;
    logic [WAYS-1:0]        at_or_after;
    logic                   wr_en;
    logic [VICTIM_W-1:0]    victim;
    logic                   out_free;

    // output register
    logic                   m_tvalid_reg;
    logic [VICTIM_W-1:0]    m_victim_reg;

    assign in_set  = s_tdata[SET_FIELD_W-1:0];
    assign in_way  = s_tdata[SET_FIELD_W +: WAY_FIELD_W];
    assign in_mode = mode_t'(s_tuser[0]);
    assign in_addr = SET_W'(in_set);

    // out-of-range checks fold away when the fields cannot exceed the depth
    assign in_set_ok = (int'(in_set) < SETS);
    assign in_way_ok = (int'(in_way) < WAYS);

    // one item in flight at a time
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // read on accept and capture the item
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg     <= order_mem[in_addr];
            rd_valid_reg    <= valid_reg[in_addr];
            item_mode_reg   <= in_mode;
            item_way_reg    <= WAY_W'(in_way);
            item_addr_reg   <= in_addr;
            item_set_ok_reg <= in_set_ok;
            item_way_ok_reg <= in_way_ok;
        end
    end

    // write back in the modify cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            order_mem[item_addr_reg] <= new_order;
        end
    end

    // an entry counts as written once its first write-back lands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[item_addr_reg] <= 1'b1;
        end
    end

    // unwritten sets still hold the reset order
    assign cur_order = rd_valid_reg ? rd_data_reg : reset_order();

    // locate the touched way and mark every position from it to the mru end
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            match[i] = (cur_order[i*WAY_W +: WAY_W] == item_way_reg);
        end
        at_or_after[0] = match[0];
        for (int i = 1; i < WAYS; i++) begin
            at_or_after[i] = at_or_after[i-1] | match[i];
        end
    end

    // positions at and after the touched way shift one toward lru,
    // the touched way lands at the mru end
    always_comb begin
        for (int i = 0; i < WAYS - 1; i++) begin
            new_order[i*WAY_W +: WAY_W] = at_or_after[i] ? cur_order[(i+1)*WAY_W +: WAY_W]
                                                         : cur_order[i*WAY_W +: WAY_W];
        end
        new_order[(WAYS-1)*WAY_W +: WAY_W] = at_or_after[WAYS-1]
                                             ? item_way_reg
                                             : cur_order[(WAYS-1)*WAY_W +: WAY_W];
    end

    // touch of the mru way leaves the entry alone
    assign wr_en = (state_reg == ST_CALC) && (item_mode_reg == MODE_TOUCH) &&
                   item_set_ok_reg && item_way_ok_reg &&
                   at_or_after[WAYS-1] && !match[WAYS-1];

    // lru way, masked to the result width
    assign victim   = item_set_ok_reg ? VICTIM_W'(cur_order[WAY_W-1:0]) : '0;
    assign out_free = !m_tvalid_reg || m_tready;

    // control and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a query finishing this cycle reloads the register instead
            if (m_tvalid_reg && m_tready &&
                !(state_reg == ST_CALC && item_mode_reg == MODE_QUERY)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (item_mode_reg == MODE_TOUCH) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        // result register empties this cycle or already is empty
                        m_tvalid_reg <= 1'b1;
                        m_victim_reg <= victim;
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(8 - VICTIM_W)'(0), m_victim_reg};

endmodule

[src/tlru_checker.sv]
// port-level checker for the true lru replacement block, with its bind
`include "true_lru_way_replacement_top_assert.svh"

module tlru_checker
    import tlru_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    logic s_word;
    logic q_word;

    assign s_word = s_tvalid && s_tready;
    assign q_word = s_word && (s_tuser[0] == MODE_QUERY);

    // a stalled result word holds its value
    `TLRU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // every item goes through a read step and a modify step before the next is taken
    `TLRU_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_word, !s_tready, "input accepted on back-to-back cycles")

    // a fresh result word only follows an accepted query, through its read and modify steps
    `TLRU_ASSERT_IMPL(a_result_from_query, aclk, aresetn, $rose(m_tvalid), $past(q_word, 2), "result word without a preceding query")

endmodule

bind true_lru_way_replacement_top tlru_checker u_tlru_checker (.*);

[test/tb.sv]
// testbench of the true lru replacement top level: predicted victims checked word by word
`timescale 1ns / 1ps

module tb;
    import tlru_pkg::*;

    // victim prediction: per-set recency order plus the victims still owed
    class lru_order_tracker;
        bit [WAY_W-1:0]    rank [SETS][WAYS];   // position 0 = lru, last = mru
        bit [VICTIM_W-1:0] victim_q [$];
        int                errors;

        function new();
            for (int s = 0; s < SETS; s++) begin
                for (int i = 0; i < WAYS; i++) begin
                    rank[s][i] = WAY_W'(i);
                end
            end
            errors = 0;
        endfunction

        function int pending();
            return victim_q.size();
        endfunction

        // accepted input word: queries owe a victim, touches reorder the set
        function void note_word(mode_t mode, bit [SET_FIELD_W-1:0] set_idx,
                                bit [WAY_FIELD_W-1:0] way);
            int pos;
            pos = WAYS;
            if (mode == MODE_QUERY) begin
                if (set_idx < SETS) begin
                    victim_q.push_back(VICTIM_W'(rank[set_idx][0]));
                end else begin
                    victim_q.push_back('0);
                end
            end else if (set_idx < SETS && way < WAYS) begin
                for (int i = 0; i < WAYS; i++) begin
                    if (pos == WAYS && rank[set_idx][i] == way) pos = i;
                end
                if (pos < WAYS - 1) begin
                    for (int i = pos; i < WAYS - 1; i++) begin
                        rank[set_idx][i] = rank[set_idx][i+1];
                    end
                    rank[set_idx][WAYS-1] = WAY_W'(way);
                end
            end
        endfunction

        // accepted result word against the oldest owed victim
        function void check_victim(bit [VICTIM_W-1:0] got);
            bit [VICTIM_W-1:0] want;
            if (victim_q.size() == 0) begin
                $display("%0t: victim word %0d arrived with no query pending", $time, got);
                errors++;
            end else begin
                want = victim_q.pop_front();
                if (got !== want) begin
                    $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int RANDOM_WORDS = 1100;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [5:0] set_index, [8:6] way, [15:9] zero
    logic [0:0]  s_tuser  = '0;   // [0] mode: 0 query, 1 touch
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [2:0] victim_way, [7:3] zero

    logic        free_run = 1'b0; // when set, neither side inserts gaps
    int          idle_cycles = 0;

    lru_order_tracker sb = new;

    true_lru_way_replacement_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // gap length before a word: mostly none or short, now and then long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (free_run) return 0;
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // present one word and hold it until the block takes it
    task automatic send_word(mode_t mode, bit [SET_FIELD_W-1:0] set_idx,
                             bit [WAY_FIELD_W-1:0] way);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, way, set_idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending until every owed victim has come back
    task automatic drain_victims();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // receiver: ready in runs of random length, stalls mostly short
    initial begin
        int  run_left;
        bit  level;
        run_left = 0;
        level    = 1'b0;
        forever begin
            @(posedge aclk);
            if (run_left == 0) begin
                if (free_run || $urandom_range(0, 1)) begin
                    level    = 1'b1;
                    run_left = $urandom_range(1, 20);
                end else begin
                    level    = 1'b0;
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(1, 3);
                end
            end
            run_left--;
            m_tready <= aresetn ? level : 1'b0;
        end
    end

    // monitor: feeds the predictor, checks victims, and guards against a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_word(mode_t'(s_tuser[0]), s_tdata[5:0], s_tdata[8:6]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_victim(m_tdata[2:0]);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        bit [SET_FIELD_W-1:0] hot [4];
        bit [SET_FIELD_W-1:0] set_idx;
        int                   sent;
        int                   r;

        // reset held from the start, released once
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fresh sets at both ends of the index range
        send_word(MODE_QUERY, 6'd0, 3'd7);    // way bits ignored on a query
        send_word(MODE_QUERY, 6'd63, 3'd0);
        // touching the way that is already mru leaves the order alone
        send_word(MODE_TOUCH, 6'd63, 3'd7);
        send_word(MODE_QUERY, 6'd63, 3'd5);
        // lru way moves to the mru end, the next one becomes victim
        send_word(MODE_TOUCH, 6'd0, 3'd0);
        send_word(MODE_QUERY, 6'd0, 3'd0);
        send_word(MODE_TOUCH, 6'd0, 3'd1);
        send_word(MODE_QUERY, 6'd0, 3'd7);
        // a middle way, then the lru way
        send_word(MODE_TOUCH, 6'd5, 3'd3);
        send_word(MODE_TOUCH, 6'd5, 3'd0);
        send_word(MODE_QUERY, 6'd5, 3'd2);
        send_word(MODE_TOUCH, 6'd63, 3'd0);
        send_word(MODE_QUERY, 6'd63, 3'd7);
        // same way twice: the second touch hits the mru way
        send_word(MODE_TOUCH, 6'd42, 3'd5);
        send_word(MODE_TOUCH, 6'd42, 3'd5);
        send_word(MODE_QUERY, 6'd42, 3'd1);
        // back-to-back touches on one set, then queries on that set and on set 42
        send_word(MODE_TOUCH, 6'd21, 3'd6);
        send_word(MODE_TOUCH, 6'd21, 3'd2);
        send_word(MODE_TOUCH, 6'd21, 3'd4);
        send_word(MODE_QUERY, 6'd21, 3'd3);
        send_word(MODE_QUERY, 6'd42, 3'd0);
        // hold off until all directed victims are back
        drain_victims();

        // random: most traffic on a few hot sets so their orders get shuffled
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if (sent % 150 == 0) begin
                foreach (hot[i]) hot[i] = 6'($urandom_range(0, 63));
                hot[3] = ($urandom_range(0, 1)) ? 6'd0 : 6'd63;
            end
            free_run <= ((sent / 128) % 4 == 3);
            if (sent == RANDOM_WORDS / 2) drain_victims();
            r = $urandom_range(0, 99);
            set_idx = ($urandom_range(0, 99) < 80) ? hot[$urandom_range(0, 3)]
                                                   : 6'($urandom_range(0, 63));
            if (r < 6) begin
                // fill sequence: touch a random way once per way of the set, then ask
                for (int k = 0; k < WAYS; k++) begin
                    send_word(MODE_TOUCH, set_idx, 3'($urandom_range(0, 7)));
                end
                send_word(MODE_QUERY, set_idx, 3'($urandom_range(0, 7)));
                sent += WAYS + 1;
            end else begin
                send_word((r < 60) ? MODE_TOUCH : MODE_QUERY, set_idx,
                          3'($urandom_range(0, 7)));
                sent++;
            end
        end

        drain_victims();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
